// File: src/steered_window_gradient_energy_assert.svh
// Assertion macros for the gradient energy block.
// Each macro takes a label, the clock, the active-low reset, two expressions and a message.
`ifndef STEERED_WINDOW_GRADIENT_ENERGY_ASSERT_SVH
`define STEERED_WINDOW_GRADIENT_ENERGY_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SWGE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SWGE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWGE_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define SWGE_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: src/swge_pkg.sv
package swge_pkg;

    localparam int WIN_RADIUS_DEF = 2;

    // fixed-point constants
    localparam logic [23:0] LN2_Q24   = 24'd11629080;
    localparam logic [25:0] LN2_X4    = 26'd46516320;
    localparam logic [28:0] LN2_X32   = 29'd372130560;
    localparam logic [24:0] ONE_Q24   = 25'd16777216;
    localparam logic [15:0] W_MAX     = 16'hFFFF;
    localparam logic [15:0] WS_RESET  = 16'd2048;
    localparam logic [39:0] E2_MAX    = 40'hFF_FFFF_FFFF;
    localparam logic [31:0] E1_MAX    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic signed [15:0] cov_xx;
        logic signed [15:0] cov_cross;
        logic signed [15:0] cov_yy;
    } t_in_item;

    typedef struct packed {
        logic [31:0] energy_first;
        logic [39:0] energy_second;
        logic        saturated;
    } t_out_item;

    // unit requests
    typedef struct packed {
        logic        start;
        logic [6:0]  nbits;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef struct packed {
        logic        start;
        logic [5:0]  nbits;
        logic [31:0] dividend;
        logic [23:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic         start;
        logic [6:0]   npairs;
        logic [127:0] radicand;
    } t_sqrt_req;

    typedef enum logic [5:0] {
        S_IDLE, S_AXX, S_AYY, S_AXY, S_U_GO, S_U_WAIT, S_CLASS, S_N_WAIT,
        S_H_MGO, S_H_MWAIT, S_H_DGO, S_H_DWAIT, S_RND, S_SHIFT, S_WSAT,
        S_WX_GO, S_WX_WAIT, S_WY_GO, S_WY_WAIT,
        S_GXX_GO, S_GXX_WAIT, S_GYY_GO, S_GYY_WAIT, S_GXY_GO, S_GXY_WAIT,
        S_NEXT, S_DA_GO, S_DA_WAIT, S_DB_GO, S_DB_WAIT,
        S_R_GO, S_R_WAIT, S_E_GO, S_E_WAIT, S_OUT
    } t_state;

endpackage

// File: src/swge_mul.sv
// Bit-serial unsigned multiplier, multiplier bits taken MSB first.
module swge_mul import swge_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_mul_req     i_req,
    output logic         o_done,
    output logic [127:0] o_prod
);

    logic [127:0] r_acc, n_acc;
    logic [63:0]  r_a, r_b;
    logic [6:0]   r_cnt;
    logic         r_busy, r_done;
    logic [5:0]   idx;

    // one shift-add step
    always_comb begin
        idx   = 6'(r_cnt - 7'd1);
        n_acc = {r_acc[126:0], 1'b0} + (r_b[idx] ? {64'b0, r_a} : 128'b0);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands and product
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// File: src/swge_div.sv
// Restoring divider, one quotient bit per cycle.
module swge_div import swge_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_div_req    i_req,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [23:0] o_rem
);

    logic [23:0] r_rem, r_den, n_rem;
    logic [31:0] r_num, r_q;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [4:0]  idx;
    logic [24:0] shifted;
    logic        ge;

    // trial subtract
    always_comb begin
        idx     = 5'(r_cnt - 6'd1);
        shifted = {r_rem, r_num[idx]};
        ge      = shifted >= {1'b0, r_den};
        n_rem   = ge ? 24'(shifted - {1'b0, r_den}) : shifted[23:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_q   <= '0;
            r_num <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[30:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

endmodule

// File: src/swge_sqrt.sv
// Restoring integer square root, one radicand bit pair per cycle.
module swge_sqrt import swge_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_sqrt_req   i_req,
    output logic        o_done,
    output logic [63:0] o_root
);

    logic [127:0] r_rad;
    logic [63:0]  r_root;
    logic [65:0]  r_rem, n_rem;
    logic [6:0]   r_cnt;
    logic         r_busy, r_done;
    logic [5:0]   idx;
    logic [67:0]  shifted, trial;
    logic         ge;

    // bring in next pair, try (root << 2) | 1
    always_comb begin
        idx     = 6'(r_cnt - 7'd1);
        shifted = {r_rem, r_rad[{idx, 1'b1}], r_rad[{idx, 1'b0}]};
        trial   = {2'b00, r_root, 2'b01};
        ge      = shifted >= trial;
        n_rem   = ge ? 66'(shifted - trial) : shifted[65:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.npairs;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_req.radicand;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_root <= {r_root[62:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: src/steered_window_gradient_energy.sv
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_item  (t_in_item, one window element)
// output    out        o_valid / i_ready   o_item  (t_out_item, one per window)
// config    in         i_cfg_wr_en         i_cfg_wr_data (weight_scale)
//
// An element whose weight clamps or vanishes skips the exponential. The time from an
// element's accept to the next ready is set by the bit-serial multiplier (one multiplier
// bit a cycle, fourteen products for an element that takes the exponential), the serial
// divider and the final normalizing shift. The last element of a window adds the two
// 64-bit products and the two square roots. Reset is synchronous and needs no clearing
// pass. A finished result waits in the output register; the next item is taken meanwhile,
// and only a second window end stalls until the result is taken.
`include "steered_window_gradient_energy_assert.svh"
module steered_window_gradient_energy import swge_pkg::*; #(
    parameter int WINDOW_RADIUS = WIN_RADIUS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_item,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_item,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data
);

    localparam int SIDE  = 2 * WINDOW_RADIUS + 1;
    localparam int CNT_W = $clog2(SIDE);
    localparam int OFF_W = CNT_W + 1;
    localparam int C_W   = 2 * OFF_W;
    localparam int A_W   = C_W + 18;
    localparam int U_W   = A_W + 16;
    localparam int V_W   = U_W + 2;

    t_state r_state, n_state;

    // control state
    logic [CNT_W-1:0] r_col, r_row;
    logic signed [63:0] r_sum_xx, r_sum_yy, r_sum_xy;
    logic r_sat, r_out_valid;
    logic [15:0] r_ws;

    // working registers
    t_in_item           r_in;
    t_out_item          r_out;
    logic signed [A_W-1:0] r_a;
    logic [4:0]         r_n4;
    logic [23:0]        r_t;
    logic [24:0]        r_p;
    logic [3:0]         r_k;
    logic [39:0]        r_w40;
    logic [5:0]         r_sh;
    logic [15:0]        r_w;
    logic [19:0]        r_mx, r_my;
    logic               r_sx, r_sy;
    logic [127:0]       r_det;
    logic [63:0]        r_root;

    // units
    t_mul_req  mul_req;
    t_div_req  div_req;
    t_sqrt_req sqrt_req;
    logic         mul_done, div_done, sqrt_done;
    logic [127:0] mul_prod;
    logic [31:0]  div_quot;
    logic [23:0]  div_rem;
    logic [63:0]  sqrt_root;

    swge_mul u_mul (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(mul_req),
        .o_done(mul_done), .o_prod(mul_prod)
    );

    swge_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(div_req),
        .o_done(div_done), .o_quot(div_quot), .o_rem(div_rem)
    );

    swge_sqrt u_sqrt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(sqrt_req),
        .o_done(sqrt_done), .o_root(sqrt_root)
    );

    // offsets and exponent terms
    logic signed [OFF_W-1:0] ox, oy;
    logic signed [C_W-1:0]   coef;
    logic signed [15:0]      cov_sel;
    logic signed [C_W+15:0]  term;
    logic                    last_elem;

    always_comb begin
        ox = $signed({1'b0, r_col}) - $signed(OFF_W'(WINDOW_RADIUS));
        oy = $signed({1'b0, r_row}) - $signed(OFF_W'(WINDOW_RADIUS));
        unique case (r_state)
            S_AXX: begin
                coef = ox * ox;
                cov_sel = r_in.cov_xx;
            end
            S_AYY: begin
                coef = oy * oy;
                cov_sel = r_in.cov_yy;
            end
            default: begin
                coef = ox * oy;
                cov_sel = r_in.cov_cross;
            end
        endcase
        term = coef * cov_sel;
        last_elem = (r_col == CNT_W'(SIDE - 1)) && (r_row == CNT_W'(SIDE - 1));
    end

    // exponent magnitude, range split
    logic                   a_neg;
    logic [A_W-1:0]         a_mag;
    logic signed [V_W-1:0]  u_s, v_val;
    logic                   v_neg, v_big;

    always_comb begin
        a_neg = r_a[A_W-1];
        a_mag = a_neg ? A_W'(-r_a) : A_W'(r_a);
        u_s   = $signed({2'b00, mul_prod[U_W-1:0]});
        v_val = (a_neg ? -u_s : u_s) + $signed(V_W'(LN2_X4));
        v_neg = v_val[V_W-1];
        v_big = !v_neg && ($unsigned(v_val) >= V_W'(LN2_X32));
    end

    // gradient magnitudes, rounding, window-end terms
    logic [15:0] gx_mag, gy_mag;
    logic [32:0] rnd;
    logic [63:0] sxy_mag, trace;
    logic [56:0] e2_wide;
    logic        out_load;

    always_comb begin
        gx_mag  = r_in.grad_x[15] ? 16'(-r_in.grad_x) : 16'(r_in.grad_x);
        gy_mag  = r_in.grad_y[15] ? 16'(-r_in.grad_y) : 16'(r_in.grad_y);
        rnd     = 33'(mul_prod[31:0]) + 33'd2048;
        sxy_mag = r_sum_xy[63] ? 64'(-r_sum_xy) : 64'(r_sum_xy);
        trace   = 64'(r_sum_xx) + 64'(r_sum_yy) + {r_root[62:0], 1'b0};
        e2_wide = 57'(({1'b0, r_root} + 65'd128) >> 8);
        out_load = (r_state == S_OUT) && (!r_out_valid || i_ready);
    end

    // state groups watched by the checks
    logic in_mul_wait, in_div_wait, win_clear;

    always_comb begin
        in_mul_wait = (r_state == S_U_WAIT) || (r_state == S_H_MWAIT)
                      || (r_state == S_WX_WAIT) || (r_state == S_WY_WAIT)
                      || (r_state == S_GXX_WAIT) || (r_state == S_GYY_WAIT)
                      || (r_state == S_GXY_WAIT) || (r_state == S_DA_WAIT)
                      || (r_state == S_DB_WAIT);
        in_div_wait = (r_state == S_N_WAIT) || (r_state == S_H_DWAIT);
        win_clear   = (r_sum_xx == 64'sd0) && (r_sum_yy == 64'sd0) && (r_sum_xy == 64'sd0)
                      && (r_col == '0) && (r_row == '0) && !r_sat;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_valid) n_state = S_AXX;
            S_AXX:      n_state = S_AYY;
            S_AYY:      n_state = S_AXY;
            S_AXY:      n_state = S_U_GO;
            S_U_GO:     n_state = S_U_WAIT;
            S_U_WAIT:   if (mul_done) n_state = S_CLASS;
            S_CLASS:    n_state = (v_neg || v_big) ? S_WX_GO : S_N_WAIT;
            S_N_WAIT:   if (div_done) n_state = S_H_MGO;
            S_H_MGO:    n_state = S_H_MWAIT;
            S_H_MWAIT:  if (mul_done) n_state = S_H_DGO;
            S_H_DGO:    n_state = S_H_DWAIT;
            S_H_DWAIT:  if (div_done) n_state = (r_k == 4'd1) ? S_RND : S_H_MGO;
            S_RND:      n_state = S_SHIFT;
            S_SHIFT:    if (r_sh == 6'd0) n_state = S_WSAT;
            S_WSAT:     n_state = S_WX_GO;
            S_WX_GO:    n_state = S_WX_WAIT;
            S_WX_WAIT:  if (mul_done) n_state = S_WY_GO;
            S_WY_GO:    n_state = S_WY_WAIT;
            S_WY_WAIT:  if (mul_done) n_state = S_GXX_GO;
            S_GXX_GO:   n_state = S_GXX_WAIT;
            S_GXX_WAIT: if (mul_done) n_state = S_GYY_GO;
            S_GYY_GO:   n_state = S_GYY_WAIT;
            S_GYY_WAIT: if (mul_done) n_state = S_GXY_GO;
            S_GXY_GO:   n_state = S_GXY_WAIT;
            S_GXY_WAIT: if (mul_done) n_state = S_NEXT;
            S_NEXT:     n_state = last_elem ? S_DA_GO : S_IDLE;
            S_DA_GO:    n_state = S_DA_WAIT;
            S_DA_WAIT:  if (mul_done) n_state = S_DB_GO;
            S_DB_GO:    n_state = S_DB_WAIT;
            S_DB_WAIT:  if (mul_done) n_state = S_R_GO;
            S_R_GO:     n_state = S_R_WAIT;
            S_R_WAIT:   if (sqrt_done) n_state = S_E_GO;
            S_E_GO:     n_state = S_E_WAIT;
            S_E_WAIT:   if (sqrt_done) n_state = S_OUT;
            S_OUT:      if (out_load) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // unit requests and handshake outputs
    always_comb begin
        mul_req  = '0;
        div_req  = '0;
        sqrt_req = '0;
        o_ready  = (r_state == S_IDLE);
        unique case (r_state)
            S_U_GO: begin
                mul_req = '{start: 1'b1, nbits: 7'd16, a: 64'(a_mag), b: 64'(r_ws)};
            end
            S_CLASS: begin
                div_req = '{start: !(v_neg || v_big), nbits: 6'd29,
                            dividend: 32'(v_val[28:0]), divisor: LN2_Q24};
            end
            S_H_MGO: begin
                mul_req = '{start: 1'b1, nbits: 7'd25, a: 64'(r_t), b: 64'(r_p)};
            end
            S_H_DGO: begin
                div_req = '{start: 1'b1, nbits: 6'd24,
                            dividend: 32'(mul_prod[47:24]), divisor: 24'(r_k)};
            end
            S_WX_GO: begin
                mul_req = '{start: 1'b1, nbits: 7'd16, a: 64'(gx_mag), b: 64'(r_w)};
            end
            S_WY_GO: begin
                mul_req = '{start: 1'b1, nbits: 7'd16, a: 64'(gy_mag), b: 64'(r_w)};
            end
            S_GXX_GO: begin
                mul_req = '{start: 1'b1, nbits: 7'd20, a: 64'(r_mx), b: 64'(r_mx)};
            end
            S_GYY_GO: begin
                mul_req = '{start: 1'b1, nbits: 7'd20, a: 64'(r_my), b: 64'(r_my)};
            end
            S_GXY_GO: begin
                mul_req = '{start: 1'b1, nbits: 7'd20, a: 64'(r_mx), b: 64'(r_my)};
            end
            S_DA_GO: begin
                mul_req = '{start: 1'b1, nbits: 7'd64, a: 64'(r_sum_xx), b: 64'(r_sum_yy)};
            end
            S_DB_GO: begin
                mul_req = '{start: 1'b1, nbits: 7'd64, a: sxy_mag, b: sxy_mag};
            end
            S_R_GO: begin
                sqrt_req = '{start: 1'b1, npairs: 7'd64, radicand: r_det};
            end
            S_E_GO: begin
                sqrt_req = '{start: 1'b1, npairs: 7'd32, radicand: {64'b0, trace}};
            end
            default: begin
                mul_req = '0;
            end
        endcase
    end

    // state register and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_col       <= '0;
            r_row       <= '0;
            r_sum_xx    <= '0;
            r_sum_yy    <= '0;
            r_sum_xy    <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
            r_ws        <= WS_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_ws <= i_cfg_wr_data;
            if (out_load) r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_CLASS: if (v_neg) r_sat <= 1'b1;
                S_WSAT: if (r_w40[39:16] != 24'd0) r_sat <= 1'b1;
                S_GXX_WAIT: if (mul_done) r_sum_xx <= r_sum_xx + 64'(mul_prod[39:0]);
                S_GYY_WAIT: if (mul_done) r_sum_yy <= r_sum_yy + 64'(mul_prod[39:0]);
                S_GXY_WAIT: begin
                    if (mul_done) begin
                        if (r_sx ^ r_sy) r_sum_xy <= r_sum_xy - 64'(mul_prod[39:0]);
                        else r_sum_xy <= r_sum_xy + 64'(mul_prod[39:0]);
                    end
                end
                S_NEXT: begin
                    if (!last_elem) begin
                        if (r_col == CNT_W'(SIDE - 1)) begin
                            r_col <= '0;
                            r_row <= r_row + CNT_W'(1);
                        end else begin
                            r_col <= r_col + CNT_W'(1);
                        end
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_col    <= '0;
                        r_row    <= '0;
                        r_sum_xx <= '0;
                        r_sum_yy <= '0;
                        r_sum_xy <= '0;
                        r_sat    <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    r_in <= i_item;
                    r_a  <= '0;
                end
            end
            S_AXX, S_AYY, S_AXY: r_a <= r_a + A_W'(term);
            S_CLASS: begin
                if (v_neg) r_w <= W_MAX;
                else if (v_big) r_w <= 16'd0;
            end
            S_N_WAIT: begin
                if (div_done) begin
                    r_n4 <= div_quot[4:0];
                    r_t  <= div_rem;
                    r_p  <= ONE_Q24;
                    r_k  <= 4'd8;
                end
            end
            S_H_DWAIT: begin
                if (div_done) begin
                    r_p <= ONE_Q24 - 25'(div_quot);
                    r_k <= r_k - 4'd1;
                end
            end
            S_RND: begin
                r_w40 <= 40'(r_p) + (40'd1 << (6'(r_n4) + 6'd7));
                r_sh  <= 6'(r_n4) + 6'd8;
            end
            S_SHIFT: begin
                if (r_sh != 6'd0) begin
                    r_w40 <= r_w40 >> 1;
                    r_sh  <= r_sh - 6'd1;
                end
            end
            S_WSAT: r_w <= (r_w40[39:16] != 24'd0) ? W_MAX : r_w40[15:0];
            S_WX_WAIT: begin
                if (mul_done) begin
                    r_mx <= rnd[31:12];
                    r_sx <= r_in.grad_x[15];
                end
            end
            S_WY_WAIT: begin
                if (mul_done) begin
                    r_my <= rnd[31:12];
                    r_sy <= r_in.grad_y[15];
                end
            end
            S_DA_WAIT: if (mul_done) r_det <= mul_prod;
            S_DB_WAIT: begin
                if (mul_done) r_det <= (r_det >= mul_prod) ? r_det - mul_prod : 128'd0;
            end
            S_R_WAIT: if (sqrt_done) r_root <= sqrt_root;
            S_OUT: begin
                if (out_load) begin
                    r_out.energy_first  <= (sqrt_root[63:32] != 32'd0) ? E1_MAX
                                                                     : sqrt_root[31:0];
                    r_out.energy_second <= (e2_wide[56:40] != 17'd0) ? E2_MAX
                                                                   : e2_wide[39:0];
                    r_out.saturated     <= r_sat || (sqrt_root[63:32] != 32'd0)
                                           || (e2_wide[56:40] != 17'd0);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    // checks
    `SWGE_ASSERT_IMP(a_mul_done_in_wait, i_clk, i_rst_n, mul_done, in_mul_wait, "stray mul done")
    `SWGE_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, div_done, in_div_wait, "stray div done")
    `SWGE_ASSERT_NXT(a_result_shown, i_clk, i_rst_n, out_load, o_valid, "loaded result not shown")
    `SWGE_ASSERT_NXT(a_window_cleared, i_clk, i_rst_n, out_load, win_clear, "window not cleared")

endmodule
